FILE: rtl/core/irbp_pkg.sv
// ============================================================================
// irbp_pkg: shared types and constants of the IR bi-phase decoder
// Holds the widths, codes, configuration and result types used by every file.
// ============================================================================
package irbp_pkg;

    localparam int SHIFT_BITS    = 16;
    localparam int PRESCALE_BITS = 8;
    localparam int CNT_W         = 16;
    localparam int CMD_W         = 7;
    localparam int CMD_BITS      = 6;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CMD_W-1:0] NO_SIGNAL = 7'd64;

    localparam logic [CNT_W-1:0] SILENCE_RESET  = 16'd49;
    localparam logic [CNT_W-1:0] HALF_BIT_RESET = 16'd16;
    localparam logic [CNT_W-1:0] REPEAT_RESET   = 16'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEEK = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef logic [1:0] phase_t;

    localparam phase_t SEEK_ARM   = 2'd0;
    localparam phase_t SEEK_QUIET = 2'd1;
    localparam phase_t SEEK_EDGE  = 2'd2;
    localparam phase_t READ_EDGE  = 2'd0;
    localparam phase_t READ_HALF  = 2'd1;

    typedef struct packed {
        logic [CNT_W-1:0] silence_ticks;
        logic [CNT_W-1:0] half_bit_ticks;
        logic [CNT_W-1:0] repeat_timeout;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             frame_done;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
        sat_inc = (value == {CNT_W{1'b1}}) ? value : value + 1'b1;
    endfunction

endpackage

FILE: rtl/core/irbp_if.sv
// ============================================================================
// irbp_if: valid/ready channels of the IR bi-phase decoder
// Sample channel into the decoder and command channel out of it.
// ============================================================================
interface irbp_in_if;
    logic valid;
    logic ready;
    logic ir_active;

    modport source (output valid, output ir_active, input ready);
    modport sink (input valid, input ir_active, output ready);
endinterface

interface irbp_out_if;
    logic                       valid;
    logic                       ready;
    logic [irbp_pkg::CMD_W-1:0] command;
    logic                       frame_done;

    modport source (output valid, output command, output frame_done, input ready);
    modport sink (input valid, input command, input frame_done, output ready);
endinterface

FILE: rtl/core/irbp_cfg_regs.sv
// ============================================================================
// irbp_cfg_regs: configuration registers
// Holds the silence threshold, half-bit threshold and repeat timeout.
// ============================================================================
module irbp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [irbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irbp_pkg::CNT_W-1:0]     cfg_data,
    output irbp_pkg::cfg_t                 cfg
);

    irbp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.silence_ticks  <= irbp_pkg::SILENCE_RESET;
            cfg_reg.half_bit_ticks <= irbp_pkg::HALF_BIT_RESET;
            cfg_reg.repeat_timeout <= irbp_pkg::REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irbp_pkg::CFG_SILENCE:  cfg_reg.silence_ticks  <= cfg_data;
                irbp_pkg::CFG_HALF_BIT: cfg_reg.half_bit_ticks <= cfg_data;
                irbp_pkg::CFG_REPEAT:   cfg_reg.repeat_timeout <= cfg_data;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/irbp_decode_core.sv
// ============================================================================
// irbp_decode_core: bi-phase frame state machine and tick counters
// Advances the decoder by one tick per step and presents the tick's result.
// ============================================================================
module irbp_decode_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             ir_active,
    input  irbp_pkg::cfg_t   cfg,
    output irbp_pkg::result_t result
);

    irbp_pkg::mode_t                      mode_reg, mode_next;
    irbp_pkg::phase_t                     phase_reg, phase_next;
    logic                                 last_level_reg, last_level_next;
    logic [irbp_pkg::CNT_W-1:0]           silence_count_reg, silence_count_next;
    logic [irbp_pkg::PRESCALE_BITS-1:0]   prescale_reg, prescale_next;
    logic [irbp_pkg::CNT_W-1:0]           long_count_reg, long_count_next;
    logic [irbp_pkg::SHIFT_BITS-1:0]      shift_data_reg, shift_data_next;
    logic [irbp_pkg::CMD_W-1:0]           command_reg, command_next;
    logic                                 frame_done;
    logic [irbp_pkg::CNT_W-1:0]           silence_inc;
    logic [irbp_pkg::CNT_W-1:0]           long_inc;
    logic [irbp_pkg::PRESCALE_BITS-1:0]   prescale_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= irbp_pkg::MODE_SEEK;
            phase_reg         <= irbp_pkg::SEEK_ARM;
            last_level_reg    <= 1'b0;
            silence_count_reg <= '0;
            prescale_reg      <= '0;
            long_count_reg    <= '0;
            shift_data_reg    <= '0;
            command_reg       <= '0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            phase_reg         <= phase_next;
            last_level_reg    <= last_level_next;
            silence_count_reg <= silence_count_next;
            prescale_reg      <= prescale_next;
            long_count_reg    <= long_count_next;
            shift_data_reg    <= shift_data_next;
            command_reg       <= command_next;
        end
    end

    always_comb
    begin
        silence_inc  = irbp_pkg::sat_inc(silence_count_reg);
        prescale_inc = prescale_reg + 1'b1;
        long_inc     = (prescale_inc == '0) ? irbp_pkg::sat_inc(long_count_reg)
                                            : long_count_reg;

        mode_next          = mode_reg;
        phase_next         = phase_reg;
        last_level_next    = last_level_reg;
        silence_count_next = silence_inc;
        prescale_next      = prescale_inc;
        long_count_next    = long_inc;
        shift_data_next    = shift_data_reg;
        command_next       = command_reg;
        frame_done         = 1'b0;

        case (mode_reg)
            irbp_pkg::MODE_SEEK:
            begin
                case (phase_reg)
                    irbp_pkg::SEEK_ARM:
                    begin
                        silence_count_next = '0;
                        phase_next         = irbp_pkg::SEEK_QUIET;
                        last_level_next    = ir_active;
                    end
                    irbp_pkg::SEEK_QUIET:
                    begin
                        if (ir_active == last_level_reg)
                        begin
                            if (silence_inc > cfg.silence_ticks)
                            begin
                                phase_next      = irbp_pkg::SEEK_EDGE;
                                long_count_next = '0;
                            end
                        end
                        else
                        begin
                            phase_next = irbp_pkg::SEEK_ARM;
                        end
                    end
                    irbp_pkg::SEEK_EDGE:
                    begin
                        if (ir_active != last_level_reg)
                        begin
                            phase_next         = irbp_pkg::READ_HALF;
                            silence_count_next = '0;
                            shift_data_next    = '0;
                            mode_next          = irbp_pkg::MODE_READ;
                        end
                        else if (long_inc > cfg.repeat_timeout)
                        begin
                            command_next = irbp_pkg::NO_SIGNAL;
                        end
                    end
                    default:
                    begin
                        phase_next = irbp_pkg::SEEK_ARM;
                    end
                endcase
            end
            irbp_pkg::MODE_READ:
            begin
                case (phase_reg)
                    irbp_pkg::READ_EDGE:
                    begin
                        if (ir_active != last_level_reg)
                        begin
                            last_level_next    = ir_active;
                            phase_next         = irbp_pkg::READ_HALF;
                            silence_count_next = '0;
                        end
                        else if (silence_inc > cfg.silence_ticks)
                        begin
                            phase_next   = irbp_pkg::READ_HALF;
                            mode_next    = irbp_pkg::MODE_IDLE;
                            command_next = {1'b0, ~shift_data_reg[irbp_pkg::CMD_BITS:1]};
                            frame_done   = 1'b1;
                        end
                    end
                    irbp_pkg::READ_HALF:
                    begin
                        if (silence_inc > cfg.half_bit_ticks)
                        begin
                            phase_next      = irbp_pkg::READ_EDGE;
                            last_level_next = ir_active;
                            shift_data_next = {shift_data_reg[irbp_pkg::SHIFT_BITS-2:0],
                                               ir_active};
                        end
                    end
                    default:
                    begin
                        phase_next = irbp_pkg::READ_EDGE;
                    end
                endcase
            end
            default:
            begin
                mode_next  = irbp_pkg::MODE_SEEK;
                phase_next = irbp_pkg::SEEK_ARM;
            end
        endcase
    end

    assign result.command    = command_next;
    assign result.frame_done = frame_done;

endmodule

FILE: rtl/core/ir_remote_biphase_decoder.sv
// ============================================================================
// ir_remote_biphase_decoder: IR remote bi-phase command decoder
// Decodes one demodulated receiver sample per transaction into a command.
// ============================================================================
// Each transaction on ir_in carries one receiver level sample, taken once per
// timer tick, with 1 meaning the receiver pin is low. For every accepted
// sample the decoder returns exactly one transaction on cmd_out: the current
// command (a 6-bit code, or 64 when no signal has been seen for the repeat
// timeout) and frame_done, which is high on the tick in which a frame ended.
// The result appears on cmd_out in the cycle after the sample is accepted. The
// whole tick update is combinational between the state registers and the output
// register, so a new sample is accepted in every cycle while results are taken.
// When the receiver stalls, the output register holds its transaction and
// ir_in.ready drops until the held result is taken; a sample is accepted in
// the same cycle in which the held result leaves.
// The user writes configuration through cfg_we, cfg_index and cfg_data only while the
// block is idle, which the block does not enforce; index 3 writes are ignored.
// After reset the thresholds are 49, 16 and 8, the command is 0, no result is
// pending and the decoder waits for a silence before the first start edge.
// ============================================================================
module ir_remote_biphase_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    irbp_in_if.sink                        ir_in,
    irbp_out_if.source                     cmd_out,
    input  logic                           cfg_we,
    input  logic [irbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irbp_pkg::CNT_W-1:0]     cfg_data
);

    irbp_pkg::cfg_t    cfg;
    irbp_pkg::result_t result;
    irbp_pkg::result_t result_reg;
    logic              out_valid_reg, out_valid_next;
    logic              accept;

    irbp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    irbp_decode_core u_decode_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .ir_active (ir_in.ir_active),
        .cfg       (cfg),
        .result    (result)
    );

    assign ir_in.ready = !out_valid_reg || cmd_out.ready;
    assign accept      = ir_in.valid && ir_in.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmd_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign cmd_out.valid      = out_valid_reg;
    assign cmd_out.command    = result_reg.command;
    assign cmd_out.frame_done = result_reg.frame_done;

    // A finished frame always carries a plain 6-bit command, never the no-signal code.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_out.valid && cmd_out.frame_done |-> !cmd_out.command[irbp_pkg::CMD_W-1])
        else $error("frame_done with a command above 63");

    // A held result that is not taken blocks the next sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_out.valid && !cmd_out.ready |-> !ir_in.ready)
        else $error("sample accepted while the output is stalled");

    // Every accepted sample produces a pending result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd_out.valid)
        else $error("accepted sample produced no result");

    // A write to the silence threshold lands in the register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == irbp_pkg::CFG_SILENCE |=>
            cfg.silence_ticks == $past(cfg_data))
        else $error("silence threshold write lost");

endmodule

FILE: tb/irbp_tb_pkg.sv
// ============================================================================
// irbp_tb_pkg: command scoreboard for the IR bi-phase decoder bench
// Keeps its own tick-by-tick copy of the decoder state and thresholds, builds
// the expected command for every accepted sample transaction and compares
// each returned command transaction with the oldest one still outstanding.
// ============================================================================
package irbp_tb_pkg;

    import irbp_pkg::*;

    class command_scoreboard;

        cfg_t                     regs;
        mode_t                    mode;
        phase_t                   phase;
        logic                     last_level;
        logic [CNT_W-1:0]         silence_count;
        logic [CNT_W-1:0]         long_count;
        logic [PRESCALE_BITS-1:0] prescale;
        logic [SHIFT_BITS-1:0]    shift_reg;
        logic [CMD_W-1:0]         command_reg;
        result_t                  pending_commands[$];
        int                       mismatches;

        function new();
            regs          = '{SILENCE_RESET, HALF_BIT_RESET, REPEAT_RESET};
            mode          = MODE_SEEK;
            phase         = SEEK_ARM;
            last_level    = 1'b0;
            silence_count = '0;
            long_count    = '0;
            prescale      = '0;
            shift_reg     = '0;
            command_reg   = '0;
            mismatches    = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] value);
            return (&value) ? value : value + 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CNT_W-1:0] value);
            case (index)
                CFG_SILENCE:  regs.silence_ticks  = value;
                CFG_HALF_BIT: regs.half_bit_ticks = value;
                CFG_REPEAT:   regs.repeat_timeout = value;
                default:      ;
            endcase
        endfunction

        function int pending_count();
            return pending_commands.size();
        endfunction

        function result_t decode_tick(logic level);
            logic done;
            done = 1'b0;
            silence_count = bump(silence_count);
            prescale = prescale + 1'b1;
            if (prescale == '0)
                long_count = bump(long_count);

            case (mode)
                MODE_SEEK:
                begin
                    if (phase == SEEK_ARM)
                    begin
                        silence_count = '0;
                        phase         = SEEK_QUIET;
                        last_level    = level;
                    end
                    else if (phase == SEEK_QUIET)
                    begin
                        if (level == last_level)
                        begin
                            if (silence_count > regs.silence_ticks)
                            begin
                                phase      = SEEK_EDGE;
                                long_count = '0;
                            end
                        end
                        else
                            phase = SEEK_ARM;
                    end
                    else if (phase == SEEK_EDGE)
                    begin
                        if (level != last_level)
                        begin
                            phase         = READ_HALF;
                            silence_count = '0;
                            shift_reg     = '0;
                            mode          = MODE_READ;
                        end
                        else if (long_count > regs.repeat_timeout)
                            command_reg = NO_SIGNAL;
                    end
                    else
                        phase = SEEK_ARM;
                end
                MODE_READ:
                begin
                    if (phase == READ_EDGE)
                    begin
                        if (level != last_level)
                        begin
                            last_level    = level;
                            phase         = READ_HALF;
                            silence_count = '0;
                        end
                        else if (silence_count > regs.silence_ticks)
                        begin
                            phase       = READ_HALF;
                            mode        = MODE_IDLE;
                            command_reg = {1'b0, ~shift_reg[CMD_BITS:1]};
                            done        = 1'b1;
                        end
                    end
                    else if (phase == READ_HALF)
                    begin
                        if (silence_count > regs.half_bit_ticks)
                        begin
                            phase      = READ_EDGE;
                            last_level = level;
                            shift_reg  = {shift_reg[SHIFT_BITS-2:0], level};
                        end
                    end
                    else
                        phase = READ_EDGE;
                end
                default:
                begin
                    mode  = MODE_SEEK;
                    phase = SEEK_ARM;
                end
            endcase
            return '{command: command_reg, frame_done: done};
        endfunction

        function void note_sample(logic level);
            pending_commands.push_back(decode_tick(level));
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch %0d: %s", mismatches, what);
        endtask

        task check_result(logic [CMD_W-1:0] command, logic frame_done);
            result_t want;
            if (pending_commands.size() == 0)
                report($sformatf("command %0d with no sample outstanding", command));
            else
            begin
                want = pending_commands.pop_front();
                if (command !== want.command)
                    report($sformatf("command %0d, expected %0d", command, want.command));
                if (frame_done !== want.frame_done)
                    report($sformatf("frame_done %0b, expected %0b",
                                     frame_done, want.frame_done));
            end
        endtask

    endclass

endpackage

FILE: tb/tb_top.sv
// ============================================================================
// tb_top: bench for the IR bi-phase decoder
// Feeds receiver level samples made of well-formed bi-phase frames with random
// bits and timing, plus noise and broken frames, under several threshold
// settings including the extremes, with random gaps and stalls on both
// channels and one long stall of the command receiver. Every command
// transaction is checked against the scoreboard's own decoder.
// ============================================================================
module tb_top;

    import irbp_pkg::*;
    import irbp_tb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 500;
    localparam int HOLD_CYCLES = 60;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    irbp_in_if  in_ch ();
    irbp_out_if out_ch ();

    command_scoreboard sb = new();

    int sent_count   = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;
    bit hold_req     = 1'b0;

    ir_remote_biphase_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ir_in     (in_ch),
        .cmd_out   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_sample(in_ch.ir_active);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.command, out_ch.frame_done);
        end
        if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    // The long hold-off lets the decoder fill up while samples keep coming.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    task automatic send_sample(input logic level);
        in_ch.valid     <= 1'b1;
        in_ch.ir_active <= level;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_count++;
        if (!calm && $urandom_range(99) < 5)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) send_sample(level);
    endtask

    function automatic int half_len(input int half);
        if (half > 2)
            return half - 1 + $urandom_range(2);
        return half;
    endfunction

    task automatic send_frame(input int nbits, input int half, input int lead,
                              input int trail, input bit glitch);
        int   glitch_at;
        logic bit_value;
        glitch_at = glitch ? $urandom_range(2 * nbits - 1) : -1;
        send_run(1'b0, lead);
        for (int i = 0; i < nbits; i++)
        begin
            bit_value = (i == 0) ? 1'b1 : 1'($urandom_range(1));
            send_run(~bit_value, (2 * i == glitch_at) ? 1 : half_len(half));
            send_run(bit_value, (2 * i + 1 == glitch_at) ? 1 : half_len(half));
        end
        send_run(1'b0, trail);
    endtask

    task automatic send_noise(input int count, input int max_run);
        int left;
        int run;
        left = count;
        while (left > 0)
        begin
            run = $urandom_range(1, max_run);
            if (run > left)
                run = left;
            send_run(1'($urandom_range(1)), run);
            left -= run;
        end
    endtask

    task automatic run_traffic(input int items, input int half, input int quiet);
        int stop_at;
        int pick;
        int nbits;
        stop_at = sent_count + items;
        while (sent_count < stop_at)
        begin
            pick  = $urandom_range(99);
            nbits = ($urandom_range(9) == 0) ? 20 : $urandom_range(1, 16);
            if (pick < 75)
                send_frame(nbits, half, quiet + 2 + $urandom_range(4),
                           quiet + 2 + $urandom_range(3), 1'b0);
            else if (pick < 88)
                send_noise($urandom_range(3, 20), 2 * half + 1);
            else
                send_frame(nbits, half, quiet + 2 + $urandom_range(4),
                           $urandom_range(quiet + 3), 1'b1);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(index, value);
    endtask

    task automatic set_thresholds(input logic [CNT_W-1:0] silence,
                                  input logic [CNT_W-1:0] half_bit,
                                  input logic [CNT_W-1:0] repeat_units);
        write_reg(CFG_SILENCE, silence);
        write_reg(CFG_HALF_BIT, half_bit);
        write_reg(CFG_REPEAT, repeat_units);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.ir_active <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_SPARE, 16'hFFFF);
        cfg_we <= 1'b0;
        send_run(1'b1, 3);
        send_run(1'b0, 6);
        send_sample(1'b1);
        send_sample(1'b0);
        send_run(1'b1, 4);
        send_run(1'b0, 5);
        run_traffic(150, 12, 49);
        drain();

        set_thresholds(16'd10, 16'd5, 16'd0);
        send_frame(8, 4, 30, 14, 1'b0);
        calm = 1'b1;
        run_traffic(100, 4, 10);
        calm     = 1'b0;
        hold_req = 1'b1;
        run_traffic(150, 4, 10);
        drain();

        set_thresholds(16'd0, 16'd0, 16'hFFFF);
        run_traffic(150, 1, 0);
        drain();

        set_thresholds(16'd4, 16'hFFFF, 16'hFFFF);
        send_frame(2, 2, 8, 40, 1'b0);
        send_noise(20, 3);
        drain();

        set_thresholds(16'hFFFF, 16'd0, 16'd1);
        send_noise(60, 6);
        drain();

        set_thresholds(16'd20, 16'd9, 16'd1);
        send_frame(4, 6, 560, 24, 1'b0);
        run_traffic(100, 6, 20);
        drain();

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
